>>> design/lzss4k_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LZSS decompressor (4 KiB window).
// No dependencies; used by every module of the block.
package lzss4k_pkg;

  localparam int WINDOW_DEPTH  = 4096;
  localparam int POSITION_BIAS = 18;
  localparam int ADDR_W        = $clog2(WINDOW_DEPTH);
  localparam int COUNT_W       = ADDR_W + 1;
  localparam int LEN_W         = 5;

  localparam logic [ADDR_W-1:0]  RING_START = ADDR_W'(WINDOW_DEPTH - POSITION_BIAS);
  localparam logic [COUNT_W-1:0] WINDOW_FULL = COUNT_W'(WINDOW_DEPTH);
  localparam logic [LEN_W-1:0]   MIN_MATCH  = LEN_W'(3);
  localparam logic [3:0]         FLAGS_PER_BYTE = 4'd8;

  // One compressed byte per item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_item_t;

  // One decompressed byte per item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // Token parser phase
  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_REF2  = 2'd2
  } phase_t;

  // Control sequencer state
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RD   = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // History memory request
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] raddr;
    logic              wr_en;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
  } mem_req_t;

  // Push of one result into the output register
  typedef struct packed {
    logic      push;
    out_item_t item;
  } out_push_t;

endpackage

>>> design/lzss4k_ram.sv
`timescale 1ns / 1ps
// History window: 4096 x 8 single-clock RAM, one write and one registered read port.
// Depends on lzss4k_pkg.
module lzss4k_ram (
  input  logic                  clk,
  input  lzss4k_pkg::mem_req_t  req,
  output logic [7:0]            rdata
);

  logic [7:0] mem [lzss4k_pkg::WINDOW_DEPTH];
  logic [7:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/lzss4k_ctrl.sv
`timescale 1ns / 1ps
// Token parser and copy sequencer: decodes flags/literals/references, drives
// the history RAM and pushes decompressed bytes. Depends on lzss4k_pkg.
module lzss4k_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lzss4k_pkg::in_item_t   in_data,
  input  logic                   out_can_load,
  input  logic [7:0]             mem_rdata,
  output lzss4k_pkg::mem_req_t   mem_req,
  output lzss4k_pkg::out_push_t  out_push
);

  localparam int AW = lzss4k_pkg::ADDR_W;
  localparam int CW = lzss4k_pkg::COUNT_W;
  localparam int LW = lzss4k_pkg::LEN_W;

  lzss4k_pkg::state_t state_r, state_nxt;
  lzss4k_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]    flag_bits_r, flag_bits_nxt;
  logic [3:0]    flags_left_r, flags_left_nxt;
  logic [7:0]    held_low_r, held_low_nxt;
  logic [AW-1:0] wpos_r, wpos_nxt;
  logic [CW-1:0] written_r, written_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [LW-1:0] remain_r, remain_nxt;
  logic [7:0]    lit_r, lit_nxt;
  logic          is_lit_r, is_lit_nxt;
  logic          zero_r, zero_nxt;

  logic                 accept;
  logic                 emit;
  lzss4k_pkg::phase_t   eff_phase;
  logic [7:0]           eff_flags;
  logic [3:0]           eff_left;
  logic [AW-1:0]        eff_wpos;
  logic [CW-1:0]        eff_written;
  logic [3:0]           left_dec;
  lzss4k_pkg::phase_t   phase_used;
  logic [AW-1:0]        dist_raw;
  logic [CW-1:0]        back_dist;
  logic [7:0]           emit_byte;
  logic                 emit_last;

  assign accept = in_valid && in_ready;
  assign emit   = (state_r == lzss4k_pkg::ST_EMIT) && out_can_load;

  // Parser view after an optional new-stream reset
  always_comb begin
    if (in_data.stream_start) begin
      eff_phase   = lzss4k_pkg::PH_FLAG;
      eff_flags   = '0;
      eff_left    = '0;
      eff_wpos    = lzss4k_pkg::RING_START;
      eff_written = '0;
    end else begin
      eff_phase   = phase_r;
      eff_flags   = flag_bits_r;
      eff_left    = flags_left_r;
      eff_wpos    = wpos_r;
      eff_written = written_r;
    end
    left_dec   = eff_left - 4'd1;
    phase_used = (left_dec == 4'd0) ? lzss4k_pkg::PH_FLAG : lzss4k_pkg::PH_TOKEN;
  end

  // Source distance; zero distance means a full window back
  assign dist_raw  = wpos_r - src_r;
  assign back_dist = (dist_raw == '0) ? lzss4k_pkg::WINDOW_FULL : {1'b0, dist_raw};

  // Byte and last marker for the current emit
  assign emit_byte = is_lit_r ? lit_r : (zero_r ? 8'd0 : mem_rdata);
  assign emit_last = is_lit_r || (remain_r == LW'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lzss4k_pkg::ST_IDLE: begin
        if (accept) begin
          if (eff_phase == lzss4k_pkg::PH_TOKEN) begin
            if (eff_flags[0]) state_nxt = lzss4k_pkg::ST_EMIT;
          end else if (eff_phase == lzss4k_pkg::PH_REF2) begin
            state_nxt = lzss4k_pkg::ST_RD;
          end
        end
      end
      lzss4k_pkg::ST_RD:   state_nxt = lzss4k_pkg::ST_EMIT;
      lzss4k_pkg::ST_EMIT: begin
        if (emit) begin
          state_nxt = emit_last ? lzss4k_pkg::ST_IDLE : lzss4k_pkg::ST_RD;
        end
      end
      default: state_nxt = lzss4k_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    in_ready       = (state_r == lzss4k_pkg::ST_IDLE);
    phase_nxt      = phase_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    held_low_nxt   = held_low_r;
    wpos_nxt       = wpos_r;
    written_nxt    = written_r;
    src_nxt        = src_r;
    remain_nxt     = remain_r;
    lit_nxt        = lit_r;
    is_lit_nxt     = is_lit_r;
    zero_nxt       = zero_r;
    mem_req        = '0;
    out_push       = '0;

    case (state_r)
      lzss4k_pkg::ST_IDLE: begin
        if (accept) begin
          wpos_nxt       = eff_wpos;
          written_nxt    = eff_written;
          phase_nxt      = eff_phase;
          flag_bits_nxt  = eff_flags;
          flags_left_nxt = eff_left;
          if (eff_phase == lzss4k_pkg::PH_TOKEN) begin
            if (eff_flags[0]) begin
              // literal
              lit_nxt        = in_data.in_byte;
              is_lit_nxt     = 1'b1;
              flag_bits_nxt  = {1'b0, eff_flags[7:1]};
              flags_left_nxt = left_dec;
              phase_nxt      = phase_used;
            end else begin
              held_low_nxt = in_data.in_byte;
              phase_nxt    = lzss4k_pkg::PH_REF2;
            end
          end else if (eff_phase == lzss4k_pkg::PH_REF2) begin
            // second reference byte: start the copy
            src_nxt        = {in_data.in_byte[7:4], held_low_r};
            remain_nxt     = LW'(in_data.in_byte[3:0]) + lzss4k_pkg::MIN_MATCH;
            is_lit_nxt     = 1'b0;
            flag_bits_nxt  = {1'b0, eff_flags[7:1]};
            flags_left_nxt = left_dec;
            phase_nxt      = phase_used;
          end else begin
            // flag byte (unused phase code lands here too)
            flag_bits_nxt  = in_data.in_byte;
            flags_left_nxt = lzss4k_pkg::FLAGS_PER_BYTE;
            phase_nxt      = lzss4k_pkg::PH_TOKEN;
          end
        end
      end
      lzss4k_pkg::ST_RD: begin
        mem_req.rd_en = 1'b1;
        mem_req.raddr = src_r;
        zero_nxt      = (back_dist > written_r);
      end
      lzss4k_pkg::ST_EMIT: begin
        if (emit) begin
          mem_req.wr_en          = 1'b1;
          mem_req.waddr          = wpos_r;
          mem_req.wdata          = emit_byte;
          out_push.push          = 1'b1;
          out_push.item.out_byte = emit_byte;
          out_push.item.run_last = emit_last;
          wpos_nxt               = wpos_r + AW'(1);
          if (written_r != lzss4k_pkg::WINDOW_FULL) written_nxt = written_r + CW'(1);
          if (!is_lit_r) begin
            src_nxt    = src_r + AW'(1);
            remain_nxt = remain_r - LW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lzss4k_pkg::ST_IDLE;
      phase_r      <= lzss4k_pkg::PH_FLAG;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      held_low_r   <= '0;
      wpos_r       <= lzss4k_pkg::RING_START;
      written_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      held_low_r   <= held_low_nxt;
      wpos_r       <= wpos_nxt;
      written_r    <= written_nxt;
    end
  end

  // Copy payload registers
  always_ff @(posedge clk) begin
    src_r    <= src_nxt;
    remain_r <= remain_nxt;
    lit_r    <= lit_nxt;
    is_lit_r <= is_lit_nxt;
    zero_r   <= zero_nxt;
  end

endmodule

>>> design/lzss_decompressor_4k_window_core.sv
`timescale 1ns / 1ps
// Top level of the LZSS decompressor: parser/sequencer, history RAM, output register.
// Depends on lzss4k_pkg, lzss4k_ram, lzss4k_ctrl.
//
//   channel   ports                        payload
//   input     in_valid / in_ready          in_data  (in_item_t: in_byte, stream_start)
//   result    out_valid / out_ready        out_data (out_item_t: out_byte, run_last)
//
// Flag byte and first reference byte: accepted with no result.
// Literal: accepted, then written to RAM and output register.
// Reference of length L (3..18): accepted, then each copied byte needs a RAM
// read state and a write/emit state on the single history RAM.
// Reset is synchronous on rst_n; the history RAM is not cleared.
// A full output register stalls the emit cycle; input is taken only between items.
module lzss_decompressor_4k_window_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lzss4k_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lzss4k_pkg::out_item_t out_data
);

  lzss4k_pkg::mem_req_t  mem_req;
  lzss4k_pkg::out_push_t out_push;
  logic [7:0]            mem_rdata;
  logic                  out_can_load;
  logic                  out_valid_r, out_valid_nxt;
  lzss4k_pkg::out_item_t out_item_r, out_item_nxt;

  lzss4k_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_can_load (out_can_load),
    .mem_rdata    (mem_rdata),
    .mem_req      (mem_req),
    .out_push     (out_push)
  );

  lzss4k_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Output register
  assign out_can_load  = !out_valid_r || out_ready;
  assign out_valid_nxt = out_push.push || (out_valid_r && !out_ready);
  assign out_item_nxt  = out_push.push ? out_push.item : out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

>>> design/lzss4k_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the LZSS decompressor, bound to the top level.
// Depends on lzss4k_pkg and lzss_decompressor_4k_window_core.
module lzss4k_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input lzss4k_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input lzss4k_pkg::out_item_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Waiting input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while waiting");

  // Nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // While open for input, any waiting result closes its run
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_data.run_last)
    else $error("input open while a run is unfinished");

  // Mid-run byte waiting: the copy is still going, input stays closed
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.run_last |-> !in_ready)
    else $error("input opened in the middle of a run");

endmodule

bind lzss_decompressor_4k_window_core lzss4k_chk u_chk (.*);
